[design/dbd_pkg.sv]
package dbd_pkg;

  localparam int unsigned DayW   = 5;
  localparam int unsigned MonW   = 4;
  localparam int unsigned YearW  = 14;
  localparam int unsigned DiffW  = 23;
  localparam int unsigned NumW   = 23;
  localparam int unsigned Q100W  = 8;
  localparam int unsigned DbmW   = 9;
  localparam int unsigned OffW   = 10;

  // floor(x / 100) == (x * Recip100) >> Recip100Shift for every x below 2**15
  localparam logic [12:0] Recip100      = 13'd5243;
  localparam int unsigned Recip100Shift = 19;
  localparam int unsigned RecipProdW    = YearW + 13;

  localparam logic [MonW-1:0] MonJan = 4'd1;
  localparam logic [MonW-1:0] MonFeb = 4'd2;
  localparam logic [MonW-1:0] MonDec = 4'd12;

  // Pipeline advance strobes, one per payload stage of a date.
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
  } adv_t;

  // Days in the whole months before the given month (month already clamped 1..12).
  function automatic logic [DbmW-1:0] days_before_month(input logic [MonW-1:0] mon);
    logic [DbmW-1:0] dbm;
    case (mon)
      4'd1:    dbm = 9'd0;
      4'd2:    dbm = 9'd31;
      4'd3:    dbm = 9'd59;
      4'd4:    dbm = 9'd90;
      4'd5:    dbm = 9'd120;
      4'd6:    dbm = 9'd151;
      4'd7:    dbm = 9'd181;
      4'd8:    dbm = 9'd212;
      4'd9:    dbm = 9'd243;
      4'd10:   dbm = 9'd273;
      4'd11:   dbm = 9'd304;
      4'd12:   dbm = 9'd334;
      default: dbm = 9'd0;
    endcase
    return dbm;
  endfunction

endpackage

[design/dbd_in_if.sv]
interface dbd_in_if;
  logic                         valid;
  logic                         ready;
  logic [dbd_pkg::DayW-1:0]     first_day;
  logic [dbd_pkg::MonW-1:0]     first_month;
  logic [dbd_pkg::YearW-1:0]    first_year;
  logic [dbd_pkg::DayW-1:0]     second_day;
  logic [dbd_pkg::MonW-1:0]     second_month;
  logic [dbd_pkg::YearW-1:0]    second_year;

  modport source (
    output valid, first_day, first_month, first_year,
    output second_day, second_month, second_year,
    input  ready
  );

  modport sink (
    input  valid, first_day, first_month, first_year,
    input  second_day, second_month, second_year,
    output ready
  );
endinterface

[design/dbd_out_if.sv]
interface dbd_out_if;
  logic                             valid;
  logic                             ready;
  logic signed [dbd_pkg::DiffW-1:0] day_difference;

  modport source (
    output valid, day_difference,
    input  ready
  );

  modport sink (
    input  valid, day_difference,
    output ready
  );
endinterface

[design/days_between_dates.sv]
// days_between_dates: signed day count from a first Gregorian date to a second.
//
// Input channel in_i (sink): one transaction carries both dates as day, month
// and year fields. Output channel out_o (source): one transaction per input,
// day_difference = day number of the second date minus that of the first,
// two's complement, saturated to the 23-bit range. Months below 1 count as
// January, above 12 as December; days are added without a range check.
//
// out_o.valid rises once the transaction has passed all four register stages;
// the first of them loads at the accepting edge. Throughput: one transaction
// per cycle while out_o.ready stays high, set by a four-stage pipeline (month
// table and reciprocal divide by 100, year multiply and leap counts, day-number
// sum, difference and saturation). Each stage holds a valid bit.
//
// Reset clears all valid bits; the pipeline comes up empty and ready.
// When the receiver stalls, the stages behind the output register keep
// advancing into empty slots, so bubbles are squeezed out; once all stages
// hold data, in_i.ready drops and every stage holds its transaction.
module days_between_dates (
  input  logic      clk_i,
  input  logic      rst_ni,
  dbd_in_if.sink    in_i,
  dbd_out_if.source out_o
);

  logic v1_q, v2_q, v3_q, v4_q;
  logic adv4;
  dbd_pkg::adv_t adv;

  // Advance a stage when it is empty or the stage after it advances.
  assign adv4   = !v4_q || out_o.ready;
  assign adv.s3 = !v3_q || adv4;
  assign adv.s2 = !v2_q || adv.s3;
  assign adv.s1 = !v1_q || adv.s2;

  assign in_i.ready = adv.s1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (adv.s1) v1_q <= in_i.valid;
      if (adv.s2) v2_q <= v1_q;
      if (adv.s3) v3_q <= v2_q;
      if (adv4)   v4_q <= v3_q;
    end
  end

  // Day numbers of both dates, three stages each.
  logic [dbd_pkg::NumW-1:0] num_first;
  logic [dbd_pkg::NumW-1:0] num_second;

  dbd_day_num u_first (
    .clk_i   (clk_i),
    .adv_i   (adv),
    .day_i   (in_i.first_day),
    .month_i (in_i.first_month),
    .year_i  (in_i.first_year),
    .num_o   (num_first)
  );

  dbd_day_num u_second (
    .clk_i   (clk_i),
    .adv_i   (adv),
    .day_i   (in_i.second_day),
    .month_i (in_i.second_month),
    .year_i  (in_i.second_year),
    .num_o   (num_second)
  );

  // Output stage: difference with one guard bit, then saturate.
  logic signed [dbd_pkg::DiffW:0]   diff_wide;
  logic signed [dbd_pkg::DiffW-1:0] diff_sat;
  logic signed [dbd_pkg::DiffW-1:0] diff_q;

  assign diff_wide = $signed({1'b0, num_second}) - $signed({1'b0, num_first});

  always_comb begin
    if (diff_wide[dbd_pkg::DiffW] != diff_wide[dbd_pkg::DiffW-1]) begin
      // Overflow: clamp toward the sign of the wide result.
      diff_sat = diff_wide[dbd_pkg::DiffW] ? {1'b1, {(dbd_pkg::DiffW-1){1'b0}}}
                                           : {1'b0, {(dbd_pkg::DiffW-1){1'b1}}};
    end else begin
      diff_sat = diff_wide[dbd_pkg::DiffW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv4) begin
      diff_q <= diff_sat;
    end
  end

  assign out_o.valid          = v4_q;
  assign out_o.day_difference = diff_q;

endmodule

[design/dbd_day_num.sv]
module dbd_day_num (
  input  logic                          clk_i,
  input  dbd_pkg::adv_t                 adv_i,
  input  logic [dbd_pkg::DayW-1:0]      day_i,
  input  logic [dbd_pkg::MonW-1:0]      month_i,
  input  logic [dbd_pkg::YearW-1:0]     year_i,
  output logic [dbd_pkg::NumW-1:0]      num_o
);

  // Stage 1: clamp month, look up month offset, divide year by 100.
  logic [dbd_pkg::MonW-1:0]       mon_clamped;
  logic [dbd_pkg::RecipProdW-1:0] recip_prod;

  logic [dbd_pkg::YearW-1:0]      year1_q;
  logic [dbd_pkg::DayW-1:0]       day1_q;
  logic [dbd_pkg::DbmW-1:0]       dbm1_q;
  logic                           late1_q;
  logic [dbd_pkg::Q100W-1:0]      q100_1_q;

  always_comb begin
    if (month_i < dbd_pkg::MonJan) begin
      mon_clamped = dbd_pkg::MonJan;
    end else if (month_i > dbd_pkg::MonDec) begin
      mon_clamped = dbd_pkg::MonDec;
    end else begin
      mon_clamped = month_i;
    end
  end

  assign recip_prod = dbd_pkg::RecipProdW'(year_i) * dbd_pkg::RecipProdW'(dbd_pkg::Recip100);

  always_ff @(posedge clk_i) begin
    if (adv_i.s1) begin
      year1_q  <= year_i;
      day1_q   <= day_i;
      dbm1_q   <= dbd_pkg::days_before_month(mon_clamped);
      late1_q  <= (mon_clamped > dbd_pkg::MonFeb);
      q100_1_q <= recip_prod[dbd_pkg::Recip100Shift +: dbd_pkg::Q100W];
    end
  end

  // Stage 2: 365 * year, leap counts, leap flag and in-year offset.
  logic [dbd_pkg::YearW-1:0] cent_part;
  logic [dbd_pkg::YearW-1:0] rem100;
  logic                      rem100_nz;
  logic                      leap;

  logic [dbd_pkg::NumW-1:0]  y365_2_q;
  logic [12:0]               ceil4_2_q;
  logic [dbd_pkg::Q100W-1:0] ceil100_2_q;
  logic [5:0]                ceil400_2_q;
  logic [dbd_pkg::OffW-1:0]  off2_q;

  assign cent_part = dbd_pkg::YearW'(q100_1_q) * dbd_pkg::YearW'(100);
  assign rem100    = year1_q - cent_part;
  assign rem100_nz = (rem100 != '0);
  assign leap      = ((year1_q[1:0] == 2'b00) && rem100_nz) ||
                     (!rem100_nz && (q100_1_q[1:0] == 2'b00));

  always_ff @(posedge clk_i) begin
    if (adv_i.s2) begin
      y365_2_q    <= dbd_pkg::NumW'(year1_q) * dbd_pkg::NumW'(365);
      ceil4_2_q   <= 13'(year1_q[dbd_pkg::YearW-1:2]) + 13'(year1_q[1:0] != 2'b00);
      ceil100_2_q <= q100_1_q + dbd_pkg::Q100W'(rem100_nz);
      ceil400_2_q <= 6'(q100_1_q[dbd_pkg::Q100W-1:2])
                     + 6'((q100_1_q[1:0] != 2'b00) || rem100_nz);
      off2_q      <= dbd_pkg::OffW'(dbm1_q) + dbd_pkg::OffW'(late1_q && leap)
                     + dbd_pkg::OffW'(day1_q);
    end
  end

  // Stage 3: sum into the day number.
  logic [dbd_pkg::NumW-1:0] num3_q;

  always_ff @(posedge clk_i) begin
    if (adv_i.s3) begin
      num3_q <= y365_2_q + dbd_pkg::NumW'(ceil4_2_q) - dbd_pkg::NumW'(ceil100_2_q)
                + dbd_pkg::NumW'(ceil400_2_q) + dbd_pkg::NumW'(off2_q);
    end
  end

  assign num_o = num3_q;

endmodule
